>>> rtl/lpri_pkg.sv
package lpri_pkg;

    // Image geometry.
    localparam int COLUMNS = 2048;
    localparam int ROWS    = 128;

    // Field widths.
    localparam int XW   = 18;
    localparam int IW   = 16;
    localparam int CFGW = 15;
    localparam int ROWW = 7;
    localparam int COLW = 11;

    // Horizontal radius: r2 = x*x + y*y, then isqrt(r2 * 2^20).
    localparam int R2W   = 36;
    localparam int SQ_SH = 20;
    localparam int SQW   = 57;
    localparam int SQN   = 28;
    localparam int SQIW  = 5;
    localparam int RW    = 28;

    // CORDIC datapath and angles in 2^-20 turn.
    localparam int CW      = 48;
    localparam int AW      = 22;
    localparam int CN      = 19;
    localparam int CIW     = 5;
    localparam int OP_SH   = 24;
    localparam int R_SH    = 14;
    localparam int QUARTER = 262144;

    // Column and row arithmetic.
    localparam int TW    = 40;
    localparam int MW    = 48;
    localparam int RB    = $clog2(ROWS);
    localparam int DIW   = 3;
    localparam int ROWFW = 9;

    // Pipeline stage positions.
    localparam int ST_IN  = 0;
    localparam int ST_SQR = 1;
    localparam int ST_SUM = 2;
    localparam int ST_SQ0 = 3;
    localparam int ST_PRE = ST_SQ0 + SQN;
    localparam int ST_CO0 = ST_PRE + 1;
    localparam int ST_P1  = ST_CO0 + CN;
    localparam int ST_P2  = ST_P1 + 1;
    localparam int ST_P3  = ST_P2 + 1;
    localparam int ST_P4  = ST_P3 + 1;
    localparam int ST_DV0 = ST_P4 + 1;
    localparam int NST    = ST_DV0 + RB;

    // Register addresses (word index).
    localparam logic REG_UPPER = 1'b0;
    localparam logic REG_LOWER = 1'b1;

    // Per-item side data that travels down the pipeline.
    typedef struct packed {
        logic            ok;
        logic            hz;
        logic [IW-1:0]   inten;
        logic [XW-1:0]   x;
        logic [XW-1:0]   y;
        logic [XW-1:0]   z;
        logic [COLW-1:0] col;
    } side_t;

    // atan(2^-i) rounded to 2^-20 turn.
    function automatic logic signed [AW-1:0] atan_lut(input logic [CIW-1:0] idx);
        logic signed [AW-1:0] v;
        unique case (idx)
            5'd0:    v = 22'sd131072;
            5'd1:    v = 22'sd77376;
            5'd2:    v = 22'sd40884;
            5'd3:    v = 22'sd20753;
            5'd4:    v = 22'sd10417;
            5'd5:    v = 22'sd5213;
            5'd6:    v = 22'sd2607;
            5'd7:    v = 22'sd1304;
            5'd8:    v = 22'sd652;
            5'd9:    v = 22'sd326;
            5'd10:   v = 22'sd163;
            5'd11:   v = 22'sd81;
            5'd12:   v = 22'sd41;
            5'd13:   v = 22'sd20;
            5'd14:   v = 22'sd10;
            5'd15:   v = 22'sd5;
            5'd16:   v = 22'sd3;
            5'd17:   v = 22'sd1;
            5'd18:   v = 22'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/lpri_sqrt_cell.sv
module lpri_sqrt_cell import lpri_pkg::*; (
    input  logic            aclk,
    input  logic            i_en,
    input  logic [SQIW-1:0] i_idx,
    input  logic [SQW-1:0]  i_rem,
    input  logic [SQW-1:0]  i_res,
    output logic [SQW-1:0]  o_rem,
    output logic [SQW-1:0]  o_res
);

    logic [SQW-1:0] sq_bit;
    logic [SQW-1:0] trial;
    logic [SQW-1:0] rem_reg, rem_next;
    logic [SQW-1:0] res_reg, res_next;

    // One result bit of the restoring square root.
    always_comb begin
        sq_bit = SQW'(1) << {i_idx, 1'b0};
        trial  = i_res + sq_bit;
        if (i_rem >= trial) begin
            rem_next = i_rem - trial;
            res_next = (i_res >> 1) + sq_bit;
        end else begin
            rem_next = i_rem;
            res_next = i_res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_en) begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign o_rem = rem_reg;
    assign o_res = res_reg;

endmodule

>>> rtl/lpri_cordic_cell.sv
module lpri_cordic_cell import lpri_pkg::*; (
    input  logic                 aclk,
    input  logic                 i_en,
    input  logic [CIW-1:0]       i_idx,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [AW-1:0] i_acc,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [AW-1:0] o_acc
);

    logic signed [CW-1:0] dx, dy;
    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [AW-1:0] acc_reg, acc_next;

    // One vectoring micro-rotation toward y = 0, floor shifts.
    always_comb begin
        dx = i_x >>> i_idx;
        dy = i_y >>> i_idx;
        if (!i_y[CW-1]) begin
            x_next   = i_x + dy;
            y_next   = i_y - dx;
            acc_next = i_acc + atan_lut(i_idx);
        end else begin
            x_next   = i_x - dy;
            y_next   = i_y + dx;
            acc_next = i_acc - atan_lut(i_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (i_en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            acc_reg <= acc_next;
        end
    end

    assign o_x   = x_reg;
    assign o_y   = y_reg;
    assign o_acc = acc_reg;

endmodule

>>> rtl/lpri_div_cell.sv
module lpri_div_cell import lpri_pkg::*; (
    input  logic           aclk,
    input  logic           i_en,
    input  logic [DIW-1:0] i_idx,
    input  logic [MW-1:0]  i_div,
    input  logic [MW-1:0]  i_rem,
    input  logic [RB-1:0]  i_q,
    output logic [MW-1:0]  o_rem,
    output logic [RB-1:0]  o_q
);

    logic [MW-1:0] shifted;
    logic [MW-1:0] rem_reg, rem_next;
    logic [RB-1:0] q_reg, q_next;

    // One quotient bit of the restoring division.
    always_comb begin
        shifted = i_div << i_idx;
        if (i_rem >= shifted) begin
            rem_next = i_rem - shifted;
            q_next   = i_q | (RB'(1) << i_idx);
        end else begin
            rem_next = i_rem;
            q_next   = i_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (i_en) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign o_rem = rem_reg;
    assign o_q   = q_reg;

endmodule

>>> rtl/lidar_point_to_range_image_pixel.sv
// Lidar point to range-image pixel.
// Input stream (s_*): one word per lidar point, the point coordinates in mm
// and its intensity in s_tdata, the finite flag in s_tuser. Output stream
// (m_*): one word per point with row, column and pixel value in m_tdata and
// the pixel-valid flag in m_tuser; invalid pixels carry all-zero fields.
// The vertical field of view is set through the APB port (upper bound at
// address 0, lower bound at address 4, hundredths of a degree); write it only
// while no points are in flight.
// Throughput is one point per cycle while the receiver does not stall. The path
// to m_tvalid runs through an input register, squares and sum, a 28-cell
// square-root chain, an operand register, two 19-cell CORDIC chains running side
// by side, four scaling stages, a 7-cell row divider and the output register.
// When the receiver stalls, the result waits in the output register; the
// pipeline keeps taking points until a finished point reaches its last cell,
// then s_tready drops until the output word is taken.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// field of view to +21.5 and -21.5 degrees.
module lidar_point_to_range_image_pixel import lpri_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input points
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // x_mm, y_mm, z_mm, intensity, pad
    input  logic [0:0]  s_tuser,   // point_finite
    // Output pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // row, col, pixel_value, pad
    output logic [0:0]  m_tuser    // pixel_valid
);

    localparam logic signed [TW-1:0] COL_GAIN = TW'(2 * (COLUMNS - 1));
    localparam logic signed [TW-1:0] COL_RND  = TW'(1 << 20);
    localparam logic signed [TW-1:0] COL_MID  = TW'(COLUMNS / 2 - 1);
    localparam logic signed [TW-1:0] COL_LIM  = TW'(COLUMNS);
    localparam logic signed [MW-1:0] B_GAIN   = MW'(36000);
    localparam logic signed [MW-1:0] M_GAIN   = MW'(2 * (ROWS - 1));
    localparam logic signed [MW-1:0] ROW_LIM  = MW'(ROWS);

    // Configuration registers.
    logic signed [CFGW-1:0] upper_reg, upper_next;
    logic signed [CFGW-1:0] lower_reg, lower_next;
    logic signed [CFGW:0]   dd;
    logic                   cfg_ok;
    logic                   wr_en;

    // Pipeline control.
    logic [NST-1:0] v_reg, v_next;
    side_t          sd_reg [NST];
    side_t          sd_next [NST];
    logic           adv;

    // Datapath registers.
    logic [R2W-1:0] xx_reg, xx_next, yy_reg, yy_next;
    logic [R2W-1:0] r2_reg, r2_next;
    logic [SQW-1:0] sq_rem [SQN+1];
    logic [SQW-1:0] sq_res [SQN+1];
    logic signed [CW-1:0] hx_s [CN+1];
    logic signed [CW-1:0] hy_s [CN+1];
    logic signed [AW-1:0] ha_s [CN+1];
    logic signed [CW-1:0] vx_s [CN+1];
    logic signed [CW-1:0] vy_s [CN+1];
    logic signed [AW-1:0] va_s [CN+1];
    logic signed [CW-1:0] hx_reg, hx_next, hy_reg, hy_next;
    logic signed [AW-1:0] ha_reg, ha_next;
    logic signed [CW-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [TW-1:0] t_reg, t_next;
    logic signed [MW-1:0] pb_reg, pb_next;
    logic signed [MW-1:0] n_reg, n_next;
    logic signed [MW-1:0] m_reg, m_next;
    logic [MW-1:0]        rem_reg, rem_next;
    logic [MW-1:0]        dv_rem [RB+1];
    logic [RB-1:0]        dv_q [RB+1];
    logic signed [MW-1:0] a_div, lim_hi;

    // Combinational helpers.
    logic signed [XW-1:0]  in_x, in_y, in_z;
    logic signed [CW-1:0]  px, py, pz;
    logic signed [AW-1:0]  a_sel;
    logic signed [TW-1:0]  kq, col_full;
    logic                  colok, rok;
    logic [ROWFW-1:0]      row_full;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [39:0]          out_data_reg, out_data_next;
    logic [0:0]           out_user_reg, out_user_next;

    // APB register access.
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign dd     = (CFGW+1)'(upper_reg) - (CFGW+1)'(lower_reg);
    assign cfg_ok = upper_reg > lower_reg;

    always_comb begin
        upper_next = upper_reg;
        lower_next = lower_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_UPPER: upper_next = pwdata[CFGW-1:0];
                REG_LOWER: lower_next = pwdata[CFGW-1:0];
                default:   upper_next = upper_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_UPPER: prdata = 32'(upper_reg);
            REG_LOWER: prdata = 32'(lower_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= CFGW'(2150);
            lower_reg <= CFGW'(-2150);
        end else begin
            upper_reg <= upper_next;
            lower_reg <= lower_next;
        end
    end

    // The pipeline moves unless a finished point meets a full, stalled output.
    assign adv      = !(out_valid_reg && !m_tready && v_reg[NST-1]);
    assign s_tready = adv;

    assign in_x = s_tdata[17:0];
    assign in_y = s_tdata[35:18];
    assign in_z = s_tdata[53:36];

    // Valid bits and side data shift one cell per advance.
    always_comb begin
        v_next     = {v_reg[NST-2:0], s_tvalid};
        sd_next[0] = '{ok:    s_tuser[0] && !(in_x == 0 && in_y == 0 && in_z == 0),
                       hz:    (in_x == 0 && in_y == 0),
                       inten: s_tdata[69:54],
                       x:     s_tdata[17:0],
                       y:     s_tdata[35:18],
                       z:     s_tdata[53:36],
                       col:   '0};
        for (int i = 1; i < NST; i++) begin
            sd_next[i] = sd_reg[i-1];
        end
        sd_next[ST_P2].col = col_full[COLW-1:0];
        sd_next[ST_P2].ok  = sd_reg[ST_P1].ok & colok;
        sd_next[ST_P4].ok  = sd_reg[ST_P3].ok & rok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NST; i++) begin
                sd_reg[i] <= sd_next[i];
            end
        end
    end

    // Squares of x and y, then their sum.
    assign xx_next = R2W'($signed(sd_reg[ST_IN].x)) * R2W'($signed(sd_reg[ST_IN].x));
    assign yy_next = R2W'($signed(sd_reg[ST_IN].y)) * R2W'($signed(sd_reg[ST_IN].y));
    assign r2_next = xx_reg + yy_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            r2_reg <= r2_next;
        end
    end

    // Square-root chain, one result bit per cell.
    assign sq_rem[0] = SQW'({r2_reg, {SQ_SH{1'b0}}});
    assign sq_res[0] = '0;

    for (genvar i = 0; i < SQN; i++) begin : g_sqrt
        lpri_sqrt_cell u_cell (
            .aclk  (aclk),
            .i_en  (adv),
            .i_idx (SQIW'(SQN - 1 - i)),
            .i_rem (sq_rem[i]),
            .i_res (sq_res[i]),
            .o_rem (sq_rem[i+1]),
            .o_res (sq_res[i+1])
        );
    end

    // CORDIC operands; a horizontal vector with negative x is turned a quarter.
    always_comb begin
        px = CW'($signed(sd_reg[ST_PRE-1].x)) <<< OP_SH;
        py = CW'($signed(sd_reg[ST_PRE-1].y)) <<< OP_SH;
        pz = CW'($signed(sd_reg[ST_PRE-1].z)) <<< OP_SH;
        hx_next = px;
        hy_next = py;
        ha_next = '0;
        if (px[CW-1]) begin
            if (!py[CW-1]) begin
                hx_next = py;
                hy_next = -px;
                ha_next = AW'(QUARTER);
            end else begin
                hx_next = -py;
                hy_next = px;
                ha_next = -AW'(QUARTER);
            end
        end
        vx_next = CW'({sq_res[SQN][RW-1:0], {R_SH{1'b0}}});
        vy_next = pz;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hx_reg <= hx_next;
            hy_reg <= hy_next;
            ha_reg <= ha_next;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
        end
    end

    assign hx_s[0] = hx_reg;
    assign hy_s[0] = hy_reg;
    assign ha_s[0] = ha_reg;
    assign vx_s[0] = vx_reg;
    assign vy_s[0] = vy_reg;
    assign va_s[0] = '0;

    // Horizontal and vertical CORDIC chains side by side.
    for (genvar j = 0; j < CN; j++) begin : g_cordic
        lpri_cordic_cell u_horz (
            .aclk  (aclk),
            .i_en  (adv),
            .i_idx (CIW'(j)),
            .i_x   (hx_s[j]),
            .i_y   (hy_s[j]),
            .i_acc (ha_s[j]),
            .o_x   (hx_s[j+1]),
            .o_y   (hy_s[j+1]),
            .o_acc (ha_s[j+1])
        );
        lpri_cordic_cell u_vert (
            .aclk  (aclk),
            .i_en  (adv),
            .i_idx (CIW'(j)),
            .i_x   (vx_s[j]),
            .i_y   (vy_s[j]),
            .i_acc (va_s[j]),
            .o_x   (vx_s[j+1]),
            .o_y   (vy_s[j+1]),
            .o_acc (va_s[j+1])
        );
    end

    // Scale the angles; a point on the vertical axis has horizontal angle zero.
    assign a_sel   = sd_reg[ST_P1-1].hz ? '0 : ha_s[CN];
    assign t_next  = TW'(a_sel) * COL_GAIN + COL_RND;
    assign pb_next = MW'(va_s[CN]) * B_GAIN;

    // Column with truncation toward zero, and the row numerator.
    always_comb begin
        if (t_reg[TW-1]) begin
            kq = -((-t_reg) >>> 21);
        end else begin
            kq = t_reg >>> 21;
        end
        col_full = COL_MID - kq;
        colok    = !col_full[TW-1] && (col_full < COL_LIM);
    end

    assign n_next = pb_reg - (MW'(lower_reg) <<< 20);
    assign m_next = n_reg * M_GAIN + (MW'(dd) <<< 20);

    // Row bound check: the quotient must land in 0 .. ROWS-1.
    assign a_div    = MW'(dd) <<< 21;
    assign lim_hi   = (MW'(dd) * ROW_LIM) <<< 21;
    assign rok      = cfg_ok && (m_reg > -a_div) && (m_reg < lim_hi);
    assign rem_next = (rok && !m_reg[MW-1]) ? m_reg : '0;

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg   <= t_next;
            pb_reg  <= pb_next;
            n_reg   <= n_next;
            m_reg   <= m_next;
            rem_reg <= rem_next;
        end
    end

    // Row divider chain, one quotient bit per cell.
    assign dv_rem[0] = rem_reg;
    assign dv_q[0]   = '0;

    for (genvar j = 0; j < RB; j++) begin : g_div
        lpri_div_cell u_cell (
            .aclk  (aclk),
            .i_en  (adv),
            .i_idx (DIW'(RB - 1 - j)),
            .i_div (a_div),
            .i_rem (dv_rem[j]),
            .i_q   (dv_q[j]),
            .o_rem (dv_rem[j+1]),
            .o_q   (dv_q[j+1])
        );
    end

    // Output word.
    assign row_full = ROWFW'(ROWS - 1) - ROWFW'(dv_q[RB]);

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (adv && v_reg[NST-1]) begin
            out_valid_next = 1'b1;
            out_user_next  = sd_reg[NST-1].ok;
            if (sd_reg[NST-1].ok) begin
                out_data_next = {6'd0, sd_reg[NST-1].inten, sd_reg[NST-1].col,
                                 row_full[ROWW-1:0]};
            end else begin
                out_data_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    // A finished point held behind a stalled output blocks new input.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && v_reg[NST-1]) |-> !s_tready)
        else $error("input accepted while the last cell was blocked");

    // A point leaving the last cell shows up on the output next cycle.
    a_last_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[NST-1] && adv) |=> m_tvalid)
        else $error("finished point did not reach the output register");

    // A valid pixel needs an open field of view.
    a_valid_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (upper_reg > lower_reg))
        else $error("valid pixel with an empty field of view");

    // Invalid pixels carry zero fields.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("invalid pixel with nonzero fields");
`endif

endmodule

>>> verif/tb_lidar_point_to_range_image_pixel.sv
module tb_lidar_point_to_range_image_pixel;
    import lpri_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Pixel word as the block reports it.
    typedef struct packed {
        logic            valid;
        logic [IW-1:0]   value;
        logic [COLW-1:0] col;
        logic [ROWW-1:0] row;
    } pixel_t;

    localparam int PIPE_LAT  = 62;
    localparam longint CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;

    // Field of view copy used for prediction.
    longint fov_upper = 2150;
    longint fov_lower = -2150;

    pixel_t expected_pixels[$];
    int     error_count = 0;
    longint cycle_count = 0;
    bit     hold_off = 1'b0;
    int     sink_gap_max = 3;
    bit     sink_no_gaps = 1'b0;

    lidar_point_to_range_image_pixel u_dut (.*);

    always #5 aclk = ~aclk;

    // Angle table in 2^-20 turn.
    function automatic longint arctan_step(input int i);
        longint tab[19] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                            652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
        return tab[i];
    endfunction

    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    // Vectoring CORDIC: angle of (xv, yv) in 2^-20 turn.
    function automatic longint vector_angle(input longint yv, input longint xv);
        longint acc, t, dx, dy;
        acc = 0;
        if (xv < 0) begin
            if (yv >= 0) begin
                t = xv; xv = yv; yv = -t; acc = QUARTER;
            end else begin
                t = xv; xv = -yv; yv = t; acc = -QUARTER;
            end
        end
        for (int i = 0; i < 19; i++) begin
            dx = shr_floor(xv, i);
            dy = shr_floor(yv, i);
            if (yv >= 0) begin
                xv += dy; yv -= dx; acc += arctan_step(i);
            end else begin
                xv -= dy; yv += dx; acc -= arctan_step(i);
            end
        end
        return acc;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Projects one point onto the range image.
    function automatic pixel_t project_point(input logic fin, input logic signed [17:0] xs,
                                             input logic signed [17:0] ys,
                                             input logic signed [17:0] zs,
                                             input logic [15:0] inten);
        longint x, y, z, a, b, k, n, d, q, r, rw, cl;
        longint unsigned r2;
        bit ok;
        pixel_t p;
        x = xs; y = ys; z = zs;
        ok = fin && !(x == 0 && y == 0 && z == 0) && (fov_upper > fov_lower);
        p = '0;
        if (ok) begin
            r2 = longint'(x * x) + longint'(y * y);
            r = int_sqrt(r2 << 20);
            a = 0;
            if (!(x == 0 && y == 0)) a = vector_angle(y <<< 24, x <<< 24);
            b = vector_angle(z <<< 24, r <<< 14);
            k = (2 * a * (COLUMNS - 1) + (64'sd1 <<< 20)) / (64'sd1 <<< 21);
            cl = COLUMNS / 2 - k - 1;
            n = b * 36000 - fov_lower * (64'sd1 <<< 20);
            d = (fov_upper - fov_lower) * (64'sd1 <<< 20);
            q = (2 * n * (ROWS - 1) + d) / (2 * d);
            rw = ROWS - q - 1;
            if (rw < 0 || rw >= ROWS || cl < 0 || cl >= COLUMNS) ok = 0;
            if (ok) begin
                p.valid = 1'b1;
                p.row = rw[ROWW-1:0];
                p.col = cl[COLW-1:0];
                p.value = inten;
            end
        end
        return p;
    endfunction

    // Sends one point and records its expected pixel when accepted.
    // tvalid stays high after the handshake until the next gap or idle period.
    task automatic send_point(input logic fin, input logic [17:0] x, input logic [17:0] y,
                              input logic [17:0] z, input logic [15:0] inten);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, inten, z, y, x};
        s_tuser  <= fin;
        do @(posedge aclk); while (!s_tready);
        expected_pixels.push_back(project_point(fin, x, y, z, inten));
        @(negedge aclk);
    endtask

    // Sends a point without a gap before it, keeping tvalid high.
    task automatic send_back_to_back(input logic [17:0] x, input logic [17:0] y,
                                     input logic [17:0] z, input logic [15:0] inten);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, inten, z, y, x};
        s_tuser  <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_pixels.push_back(project_point(1'b1, x, y, z, inten));
        @(negedge aclk);
    endtask

    // Writes one field-of-view register once the pipeline has drained.
    task automatic write_fov(input logic idx, input longint value);
        s_tvalid <= 1'b0;
        wait (expected_pixels.size() == 0);
        repeat (PIPE_LAT + 5) @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_UPPER) fov_upper = value;
        else fov_lower = value;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_fov(input longint up, input longint lo);
        write_fov(REG_UPPER, up);
        write_fov(REG_LOWER, lo);
    endtask

    function automatic logic [17:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 18'($urandom_range(0, 40) - 20);
            1: return 18'($urandom_range(0, 4000) - 2000);
            2: return 18'h20000 | 18'($urandom_range(0, 3));
            3: return 18'h1FFFF - 18'($urandom_range(0, 3));
            default: return 18'($urandom);
        endcase
    endfunction

    task automatic test_directed_points();
        send_point(1'b1, 18'd10000, 18'd0, 18'd0, 16'hFFFF);
        send_point(1'b1, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 16'h0001);
        send_point(1'b1, 18'h20000, 18'h20000, 18'h20000, 16'h8000);
        send_point(1'b1, 18'h20000, 18'd0, 18'd0, 16'h1234);
        send_point(1'b1, 18'h20000, 18'h3FFFF, 18'd5, 16'h2345);
        send_point(1'b1, 18'h20000, 18'd1, 18'd5, 16'h3456);
        send_point(1'b1, 18'd0, 18'h1FFFF, 18'd0, 16'h4567);
        send_point(1'b1, 18'd0, 18'h20000, 18'd0, 16'h5678);
        send_point(1'b0, 18'd5000, 18'd100, 18'd10, 16'hABCD);   // not finite
        send_point(1'b1, 18'd0, 18'd0, 18'd0, 16'hABCD);         // origin
        send_point(1'b0, 18'd0, 18'd0, 18'd0, 16'hFFFF);
        send_point(1'b1, 18'd0, 18'd0, 18'd1000, 16'h0F0F);      // straight up
        send_point(1'b1, 18'd0, 18'd0, 18'h3FC18, 16'hF0F0);     // straight down
        send_point(1'b1, 18'd10000, 18'd0, 18'd3939, 16'h0101);  // near top edge
        send_point(1'b1, 18'd10000, 18'd0, 18'h3F09D, 16'h0202); // near bottom edge
        send_point(1'b1, 18'd1, 18'd0, 18'd0, 16'h0000);
        send_point(1'b1, 18'h3FFFF, 18'd0, 18'd0, 16'h0303);
        send_point(1'b1, 18'h3FFFF, 18'h3FFFF, 18'd1, 16'h0404);
    endtask

    task automatic test_fov_settings();
        set_fov(9000, -9000);
        repeat (20) send_point(1'b1, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
        set_fov(-8999, -9000);
        repeat (20) send_point(1'b1, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
        set_fov(9000, 8999);
        repeat (20) send_point(1'b1, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
        // Upper not above lower makes every pixel invalid.
        set_fov(100, 100);
        repeat (10) send_point(1'b1, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
        set_fov(-9000, 9000);
        repeat (10) send_point(1'b1, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
        // Raw register bits beyond the range still exercise every bit.
        set_fov(-16384, 16383);
        repeat (5) send_point(1'b1, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
        set_fov(16383, -16384);
        repeat (10) send_point(1'b1, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
    endtask

    task automatic test_random_points(input int count);
        logic fin;
        for (int i = 0; i < count; i++) begin
            fin = ($urandom_range(0, 15) != 0);
            send_point(fin, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
        end
    endtask

    // Receiver holds off while the sender keeps offering points back to back.
    task automatic test_backpressure();
        hold_off = 1'b1;
        repeat (150) send_back_to_back(rand_coord(), rand_coord(), rand_coord(),
                                       16'($urandom));
        s_tvalid <= 1'b0;
        wait (!hold_off);
        sink_no_gaps = 1'b1;
        repeat (100) send_back_to_back(rand_coord(), rand_coord(), rand_coord(),
                                       16'($urandom));
        s_tvalid <= 1'b0;
        wait (expected_pixels.size() == 0);
        sink_no_gaps = 1'b0;
    endtask

    // Counts out the long receiver stall.
    always @(posedge aclk) begin
        static int stall_cycles = 0;
        if (hold_off) begin
            stall_cycles++;
            if (stall_cycles >= 400) hold_off <= 1'b0;
        end
    end

    // Receiver readiness with random gaps.
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (sink_no_gaps) begin
                m_tready <= 1'b1;
            end else begin
                gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, sink_gap_max);
                if (gap == 0 || $urandom_range(0, 2) == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
        end
    end

    // Compares each pixel word with the oldest expectation.
    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[0], m_tdata[ROWW+COLW+IW-1:0]};
            if (expected_pixels.size() == 0) begin
                error_count++;
                $display("%0t: unexpected pixel word %h", $time, got);
            end else begin
                want = expected_pixels.pop_front();
                if (got.valid !== want.valid) begin
                    error_count++;
                    $display("%0t: pixel_valid expected %0d actual %0d", $time,
                             want.valid, got.valid);
                end
                if (got.row !== want.row) begin
                    error_count++;
                    $display("%0t: row expected %0d actual %0d", $time, want.row, got.row);
                end
                if (got.col !== want.col) begin
                    error_count++;
                    $display("%0t: col expected %0d actual %0d", $time, want.col, got.col);
                end
                if (got.value !== want.value) begin
                    error_count++;
                    $display("%0t: pixel_value expected %h actual %h", $time,
                             want.value, got.value);
                end
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lidar_point_to_range_image_pixel regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_points();
        test_fov_settings();
        set_fov(2150, -2150);
        test_random_points(800);
        test_backpressure();
        set_fov(3000, -1000);
        test_random_points(700);
        s_tvalid <= 1'b0;
        wait (expected_pixels.size() == 0);
        repeat (PIPE_LAT + 10) @(negedge aclk);
        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("lidar_point_to_range_image_pixel regression: pass");
        end else begin
            $display("lidar_point_to_range_image_pixel regression: fail");
        end
        $finish;
    end

endmodule
